// ===== hdl/xsbr_pkg.sv =====
package xsbr_pkg;

    localparam logic [7:0] CMD_XCOMPLETE = 8'h00;
    localparam logic [7:0] CMD_XTDOMASK  = 8'h01;
    localparam logic [7:0] CMD_XSIR      = 8'h02;
    localparam logic [7:0] CMD_XRUNTEST  = 8'h04;
    localparam logic [7:0] CMD_XREPEAT   = 8'h07;
    localparam logic [7:0] CMD_XSDRSIZE  = 8'h08;
    localparam logic [7:0] CMD_XSDRTDO   = 8'h09;
    localparam logic [7:0] CMD_XSDRB     = 8'h0C;
    localparam logic [7:0] CMD_XSDRC     = 8'h0D;
    localparam logic [7:0] CMD_XSDRE     = 8'h0E;
    localparam logic [7:0] CMD_XSTATE    = 8'h12;
    localparam logic [7:0] CMD_XENDIR    = 8'h13;
    localparam logic [7:0] CMD_XENDDR    = 8'h14;

    // Highest TAP state code XSTATE may name (idle)
    localparam logic [7:0] TAP_STATE_IDLE = 8'h01;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CMD  = 2'd1,
        ST_BAD_DATA = 2'd2,
        ST_BAD_SIZE = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        status_t    status;
        logic       done_res;
    } res_t;

endpackage

// ===== hdl/xsbr_in_if.sv =====
interface xsbr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/xsbr_out_if.sv =====
interface xsbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] status;
    logic       done_res;

    modport source (output valid, output out_byte, output last_of_run, output status,
                    output done_res, input ready);
    modport sink (input valid, input out_byte, input last_of_run, input status,
                  input done_res, output ready);
endinterface

// ===== hdl/xsvf_stream_byte_reverser.sv =====
// Channel | Direction | Payload                                    | Item
// rx      | sink      | in_byte[7:0]                               | one stream byte
// tx      | source    | out_byte[7:0] last_of_run status[1:0] done_res | one converted byte
//
// A payload of N bytes is stored at one byte a cycle while rx is not held
// off; its last byte goes out straight from the input and the other bytes
// are then read back from the byte buffer, one read plus one push per byte.
// Reset clears the parser and unhalts; the buffer holds no reset value.
// tx stalls are absorbed by a two-entry output buffer; rx is held off only
// while that buffer is full or a readback or error push is in progress.
module xsvf_stream_byte_reverser
    import xsbr_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    xsbr_in_if.sink   rx,
    xsbr_out_if.source tx
);

    localparam int DEPTH = 2 * MAX_FIELD_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);

    logic          res_valid;
    res_t          res;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    res_t          slot0_reg, slot0_next;
    res_t          slot1_reg, slot1_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;
    logic          pop;

    xsbr_ctrl #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES),
        .AW              (AW),
        .LW              (LW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    xsbr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready      = (cnt_reg != 2'd2);
    assign push           = res_valid && res_ready;
    assign pop            = tx.valid && tx.ready;

    assign tx.valid       = (cnt_reg != 2'd0);
    assign tx.out_byte    = slot0_reg.out_byte;
    assign tx.last_of_run = slot0_reg.last_of_run;
    assign tx.status      = slot0_reg.status;
    assign tx.done_res    = slot0_reg.done_res;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop && push)
        begin
            if (cnt_reg == 2'd1)
            begin
                slot0_next = res;
            end
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = res;
            end
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                slot0_next = res;
            end
            else
            begin
                slot1_next = res;
            end
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ST_OK |-> res.out_byte == 8'h00 && res.last_of_run
            && !res.done_res)
        else $error("error item must be a zero final byte");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> res.status == ST_OK && res.last_of_run
            && res.out_byte == 8'h00)
        else $error("completion item malformed");

    a_halt_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        push && (res.done_res || res.status != ST_OK) |=> !res_valid)
        else $error("item produced after halt");

    a_buf_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

endmodule

// ===== hdl/xsbr_store.sv =====
module xsbr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/xsbr_ctrl.sv =====
module xsbr_ctrl
    import xsbr_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 32,
    parameter int AW              = 6,
    parameter int LW              = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    xsbr_in_if.sink       rx,
    output logic          res_valid,
    output res_t          res,
    input  logic          res_ready,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam int SCAN_LIMIT = 8 * MAX_FIELD_BYTES;

    typedef enum logic [2:0] {
        P_CMD,
        P_COPY,
        P_DROP,
        P_ENDCHK,
        P_STATECHK,
        P_SIRLEN,
        P_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_ERR,
        E_RD,
        E_PUSH
    } eng_t;

    phase_t         phase_reg, phase_next;
    eng_t           eng_reg, eng_next;
    logic           halted_reg, halted_next;
    logic           is_size_reg, is_size_next;
    logic [1:0]     arg_idx_reg, arg_idx_next;
    logic [31:0]    scan_reg, scan_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [LW-1:0]  rem_reg, rem_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    status_t        err_reg, err_next;

    logic           accept;
    logic [7:0]     b;
    logic [31:0]    scan_shift;
    logic [LW-1:0]  scan_bytes;
    logic [LW-1:0]  start_len;
    logic [5:0]     sir_bytes;

    assign rx.ready = halted_reg || (eng_reg == E_IDLE && res_ready);
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.in_byte;

    // Scan length stays within the buffer whenever a payload command uses it
    assign scan_bytes = LW'(scan_reg[LW+2:3]) + LW'(scan_reg[2:0] != 3'd0);
    assign scan_shift = {scan_reg[23:0], b};
    assign sir_bytes  = {1'b0, b[7:3]} + 6'(b[2:0] != 3'd0);

    always_comb
    begin
        start_len = '0;
        if (phase_reg == P_SIRLEN)
        begin
            start_len = LW'(sir_bytes);
        end
        else if (b == CMD_XSDRTDO)
        begin
            start_len = {scan_bytes[LW-2:0], 1'b0};
        end
        else
        begin
            start_len = scan_bytes;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        eng_next     = eng_reg;
        halted_next  = halted_reg;
        is_size_next = is_size_reg;
        arg_idx_next = arg_idx_reg;
        scan_next    = scan_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        rd_ptr_next  = rd_ptr_reg;
        err_next     = err_reg;

        res_valid       = 1'b0;
        res.out_byte    = b;
        res.last_of_run = 1'b1;
        res.status      = ST_OK;
        res.done_res    = 1'b0;

        mem_we    = 1'b0;
        mem_waddr = AW'(len_reg - rem_reg);
        mem_wdata = b;
        mem_re    = 1'b0;
        mem_raddr = rd_ptr_reg;

        case (eng_reg)
            E_IDLE:
            begin
                if (accept && !halted_reg)
                begin
                    case (phase_reg)
                        P_CMD:
                        begin
                            is_size_next = (b == CMD_XSDRSIZE);
                            case (b)
                                CMD_XCOMPLETE:
                                begin
                                    res_valid    = 1'b1;
                                    res.out_byte = 8'h00;
                                    res.done_res = 1'b1;
                                    halted_next  = 1'b1;
                                end
                                CMD_XTDOMASK, CMD_XSDRB, CMD_XSDRC, CMD_XSDRE, CMD_XSDRTDO:
                                begin
                                    res_valid = 1'b1;
                                    if (start_len != '0)
                                    begin
                                        len_next   = start_len;
                                        rem_next   = start_len;
                                        phase_next = P_PAYLOAD;
                                    end
                                end
                                CMD_XSIR:
                                begin
                                    res_valid  = 1'b1;
                                    phase_next = P_SIRLEN;
                                end
                                CMD_XRUNTEST, CMD_XSDRSIZE:
                                begin
                                    res_valid    = 1'b1;
                                    arg_idx_next = 2'd0;
                                    phase_next   = P_COPY;
                                end
                                CMD_XREPEAT:
                                begin
                                    phase_next = P_DROP;
                                end
                                CMD_XSTATE:
                                begin
                                    res_valid  = 1'b1;
                                    phase_next = P_STATECHK;
                                end
                                CMD_XENDIR, CMD_XENDDR:
                                begin
                                    phase_next = P_ENDCHK;
                                end
                                default:
                                begin
                                    res_valid    = 1'b1;
                                    res.out_byte = 8'h00;
                                    res.status   = ST_BAD_CMD;
                                    halted_next  = 1'b1;
                                end
                            endcase
                        end
                        P_COPY:
                        begin
                            res_valid    = 1'b1;
                            arg_idx_next = arg_idx_reg + 2'd1;
                            if (is_size_reg)
                            begin
                                scan_next = scan_shift;
                            end
                            if (arg_idx_reg == 2'd3)
                            begin
                                phase_next = P_CMD;
                                if (is_size_reg && scan_shift > 32'(SCAN_LIMIT))
                                begin
                                    res.last_of_run = 1'b0;
                                    err_next        = ST_BAD_SIZE;
                                    eng_next        = E_ERR;
                                end
                            end
                        end
                        P_DROP:
                        begin
                            phase_next = P_CMD;
                        end
                        P_ENDCHK:
                        begin
                            if (b != 8'h00)
                            begin
                                res_valid    = 1'b1;
                                res.out_byte = 8'h00;
                                res.status   = ST_BAD_DATA;
                                halted_next  = 1'b1;
                            end
                            phase_next = P_CMD;
                        end
                        P_STATECHK:
                        begin
                            res_valid = 1'b1;
                            if (b > TAP_STATE_IDLE)
                            begin
                                res.out_byte = 8'h00;
                                res.status   = ST_BAD_DATA;
                                halted_next  = 1'b1;
                            end
                            phase_next = P_CMD;
                        end
                        P_SIRLEN:
                        begin
                            res_valid  = 1'b1;
                            phase_next = P_CMD;
                            if ({1'b0, b} > 9'(SCAN_LIMIT))
                            begin
                                res.last_of_run = 1'b0;
                                err_next        = ST_BAD_SIZE;
                                eng_next        = E_ERR;
                            end
                            else if (start_len != '0)
                            begin
                                len_next   = start_len;
                                rem_next   = start_len;
                                phase_next = P_PAYLOAD;
                            end
                        end
                        P_PAYLOAD:
                        begin
                            mem_we   = 1'b1;
                            rem_next = rem_reg - LW'(1);
                            if (rem_reg == LW'(1))
                            begin
                                // Last byte goes out first, straight from the input
                                res_valid       = 1'b1;
                                res.last_of_run = (len_reg == LW'(1));
                                phase_next      = P_CMD;
                                if (len_reg != LW'(1))
                                begin
                                    rd_ptr_next = AW'(len_reg - LW'(2));
                                    eng_next    = E_RD;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = P_CMD;
                        end
                    endcase
                end
            end
            E_ERR:
            begin
                res_valid    = 1'b1;
                res.out_byte = 8'h00;
                res.status   = err_reg;
                if (res_ready)
                begin
                    halted_next = 1'b1;
                    eng_next    = E_IDLE;
                end
            end
            E_RD:
            begin
                mem_re   = 1'b1;
                eng_next = E_PUSH;
            end
            E_PUSH:
            begin
                res_valid       = 1'b1;
                res.out_byte    = mem_rdata;
                res.last_of_run = (rd_ptr_reg == '0);
                if (res_ready)
                begin
                    if (rd_ptr_reg == '0)
                    begin
                        eng_next = E_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                        eng_next    = E_RD;
                    end
                end
            end
            default:
            begin
                eng_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_CMD;
            eng_reg     <= E_IDLE;
            halted_reg  <= 1'b0;
            is_size_reg <= 1'b0;
            arg_idx_reg <= '0;
            scan_reg    <= '0;
            len_reg     <= '0;
            rem_reg     <= '0;
            rd_ptr_reg  <= '0;
            err_reg     <= ST_OK;
        end
        else
        begin
            phase_reg   <= phase_next;
            eng_reg     <= eng_next;
            halted_reg  <= halted_next;
            is_size_reg <= is_size_next;
            arg_idx_reg <= arg_idx_next;
            scan_reg    <= scan_next;
            len_reg     <= len_next;
            rem_reg     <= rem_next;
            rd_ptr_reg  <= rd_ptr_next;
            err_reg     <= err_next;
        end
    end

endmodule
